>>> hdl/ffbt_pkg.sv
// Package for the first-fit boundary tag allocator.
// Arena geometry, header layout and the sequencer state type; no dependencies.
package ffbt_pkg;
    localparam int ARENA_UNITS  = 4096;
    localparam int HEADER_UNITS = 2;
    localparam int FOOTER_UNITS = 1;
    localparam int AW           = $clog2(ARENA_UNITS);  // store address bits
    localparam int BW           = AW + 1;               // break pointer bits
    localparam int PW           = AW + 2;               // walk pointer bits
    localparam int SW           = AW;                   // size field bits
    localparam int HW           = SW + 2;               // header entry bits
    localparam int GW           = 14;                   // granule count of a request

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_ZERO      = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_A_RD, S_A_CHK, S_A_HD, S_EXT,
        S_F_RD, S_F_CHK, S_F_PF, S_F_PH, S_F_NR, S_F_NX, S_F_WR,
        S_T_RD, S_T_WR, S_DONE
    } t_state;
endpackage

>>> hdl/ffbt_ram.sv
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
module ffbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/first_fit_boundary_tag_allocator.sv
// First-fit heap allocator over an arena of 8-byte granules, boundary tags.
// Depends on ffbt_pkg and ffbt_ram (header store and footer store).
//
// Usage:
//   Input channel (i_valid / o_ready) carries one request: i_mode 0 is an
//   allocate of i_request_bytes, 1 is a free of payload granule i_free_address.
//   Output channel (o_valid / i_ready) returns one result per request:
//   o_payload_address and o_status (done, zero size, arena exhausted).
//   i_cfg_we / i_cfg_data write the break limit in granules; write only while idle.
//
// Walk: one request at a time. Every block visited by the address-order walk
//   takes a header read state, then a check state, because the header store
//   has a registered read. An allocate then writes its header, splitting off
//   any large tail, or extends the break; a free merges with its neighbors and
//   fixes up the tags. A zero size or null request goes straight to done.
// Reset: break pointer to 0, limit to the full arena, output empty. The stores
//   are not cleared; entries are only read after the walk has written them.
// Stall: a finished result sits in the output register; the next request is
//   accepted and worked on meanwhile, and its result waits until that transfer.
module first_fit_boundary_tag_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [15:0] i_request_bytes,
    input  logic [11:0] i_free_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_payload_address,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data
);
    localparam int AW = ffbt_pkg::AW;
    localparam int BW = ffbt_pkg::BW;
    localparam int PW = ffbt_pkg::PW;
    localparam int SW = ffbt_pkg::SW;
    localparam int HW = ffbt_pkg::HW;
    localparam int GW = ffbt_pkg::GW;
    localparam logic [PW-1:0] HU = PW'(ffbt_pkg::HEADER_UNITS);
    localparam logic [BW-1:0] ARENA = BW'(ffbt_pkg::ARENA_UNITS);
    // smallest remainder worth a split: header plus payload plus footer
    localparam logic [GW:0] SPLIT_MIN = (GW+1)'(ffbt_pkg::HEADER_UNITS + 1
                                                + ffbt_pkg::FOOTER_UNITS);

    ffbt_pkg::t_state r_state, n_state;

    logic [PW-1:0] r_a, n_a;        // walk pointer
    logic [GW-1:0] r_g, n_g;        // request in granules
    logic [PW-1:0] r_tgt, n_tgt;    // header of block to free
    logic [PW-1:0] r_s, n_s;        // working block size
    logic [PW-1:0] r_b, n_b;        // working block base
    logic          r_keep, n_keep;  // previous-free bit to keep
    logic          r_lastf, n_lastf;
    logic          r_hlo, n_hlo;    // previous-free bit of the split block
    logic [PW-1:0] r_e, n_e;        // following block whose tag gets fixed
    logic          r_flag, n_flag;
    logic [11:0]   r_addr, n_addr;
    logic [1:0]    r_st, n_st;
    logic [BW-1:0] r_bp, n_bp;      // arena break
    logic [BW-1:0] r_lim;
    logic          r_ov;
    logic [11:0]   r_oaddr;
    logic [1:0]    r_ost;

    // store ports
    logic          h_we, f_we;
    logic [AW-1:0] h_waddr, h_raddr, f_waddr, f_raddr;
    logic [HW-1:0] h_wdata, h_q;
    logic [SW-1:0] f_wdata, f_q;

    ffbt_ram #(.WIDTH(HW), .DEPTH(ffbt_pkg::ARENA_UNITS)) u_hdr (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_q)
    );
    ffbt_ram #(.WIDTH(SW), .DEPTH(ffbt_pkg::ARENA_UNITS)) u_ftr (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_q)
    );

    // header fields of the last read
    logic [PW-1:0] q_size;
    logic          q_free, q_pf;
    assign q_size = PW'(h_q[HW-1:2]);
    assign q_free = h_q[0];
    assign q_pf   = h_q[1];

    logic [PW-1:0] bp_w;
    assign bp_w = PW'(r_bp);

    logic [BW-1:0] lim_eff;
    assign lim_eff = (r_lim > ARENA) ? ARENA : r_lim;

    logic          out_free;
    assign out_free = !r_ov || i_ready;

    assign o_ready           = (r_state == ffbt_pkg::S_IDLE);
    assign o_valid           = r_ov;
    assign o_payload_address = r_oaddr;
    assign o_status          = r_ost;

    always_comb begin
        logic [GW+2:0] need;
        logic [PW-1:0] ns;
        logic [PW-1:0] p;
        n_state = r_state;
        n_a = r_a; n_g = r_g; n_tgt = r_tgt; n_s = r_s; n_b = r_b;
        n_keep = r_keep; n_lastf = r_lastf; n_hlo = r_hlo;
        n_e = r_e; n_flag = r_flag; n_addr = r_addr; n_st = r_st; n_bp = r_bp;
        h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        need = '0;
        ns   = '0;
        p    = '0;
        unique case (r_state)
            ffbt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_a = '0; n_lastf = 1'b0;
                    n_addr = '0; n_st = ffbt_pkg::ST_DONE;
                    n_g = GW'((17'(i_request_bytes) + 17'd7) >> 3);
                    n_tgt = PW'(i_free_address) - HU;
                    if (!i_mode) begin
                        if (i_request_bytes == '0) begin
                            n_st = ffbt_pkg::ST_ZERO;
                            n_state = ffbt_pkg::S_DONE;
                        end else begin
                            n_state = ffbt_pkg::S_A_RD;
                        end
                    end else if (PW'(i_free_address) < HU || r_bp == '0) begin
                        n_state = ffbt_pkg::S_DONE;
                    end else begin
                        n_state = ffbt_pkg::S_F_RD;
                    end
                end
            end
            ffbt_pkg::S_A_RD: begin
                h_raddr = AW'(r_a);
                n_state = (r_a < bp_w) ? ffbt_pkg::S_A_CHK : ffbt_pkg::S_EXT;
            end
            ffbt_pkg::S_A_CHK: begin
                if (q_free && (GW+1)'(q_size) >= (GW+1)'(r_g)) begin
                    n_addr = 12'(r_a + HU);
                    n_e    = r_a + HU + q_size;
                    if ((GW+1)'(q_size) >= (GW+1)'(r_g) + SPLIT_MIN) begin
                        // carve the tail off as a new free block
                        ns = q_size - PW'(r_g) - HU;
                        h_we = 1'b1;
                        h_waddr = AW'(r_a + HU + PW'(r_g));
                        h_wdata = {SW'(ns), 1'b0, 1'b1};
                        f_we = 1'b1;
                        f_waddr = AW'(r_a + HU + q_size - 1'b1);
                        f_wdata = SW'(ns);
                        n_flag = 1'b1;
                        n_hlo = q_pf;
                        n_state = ffbt_pkg::S_A_HD;
                    end else begin
                        h_we = 1'b1;
                        h_waddr = AW'(r_a);
                        h_wdata = {SW'(q_size), q_pf, 1'b0};
                        n_flag = 1'b0;
                        n_state = ffbt_pkg::S_T_RD;
                    end
                end else begin
                    n_lastf = q_free;
                    if (q_size == '0) begin
                        n_state = ffbt_pkg::S_EXT;
                    end else begin
                        n_a = r_a + HU + q_size;
                        n_state = ffbt_pkg::S_A_RD;
                    end
                end
            end
            ffbt_pkg::S_A_HD: begin
                h_we = 1'b1;
                h_waddr = AW'(r_a);
                h_wdata = {SW'(r_g), r_hlo, 1'b0};
                n_state = ffbt_pkg::S_T_RD;
            end
            ffbt_pkg::S_EXT: begin
                need = (GW+3)'(r_g) + (GW+3)'(ffbt_pkg::HEADER_UNITS);
                if (r_bp > lim_eff || (GW+3)'(lim_eff - r_bp) < need) begin
                    n_st = ffbt_pkg::ST_EXHAUSTED;
                end else begin
                    h_we = 1'b1;
                    h_waddr = AW'(r_bp);
                    h_wdata = {SW'(r_g), r_lastf, 1'b0};
                    n_bp = r_bp + BW'(need);
                    n_addr = 12'(bp_w + HU);
                end
                n_state = ffbt_pkg::S_DONE;
            end
            ffbt_pkg::S_F_RD: begin
                h_raddr = AW'(r_a);
                n_state = (r_a < bp_w) ? ffbt_pkg::S_F_CHK : ffbt_pkg::S_DONE;
            end
            ffbt_pkg::S_F_CHK: begin
                if (r_a == r_tgt) begin
                    n_s = q_size; n_b = r_a; n_keep = q_pf;
                    if (q_free) begin
                        n_state = ffbt_pkg::S_DONE;          // already free
                    end else if (r_a != '0 && q_pf) begin
                        f_raddr = AW'(r_a - 1'b1);
                        n_state = ffbt_pkg::S_F_PF;
                    end else begin
                        n_state = ffbt_pkg::S_F_NR;
                    end
                end else if (q_size == '0) begin
                    n_state = ffbt_pkg::S_DONE;
                end else begin
                    n_a = r_a + HU + q_size;
                    n_state = ffbt_pkg::S_F_RD;
                end
            end
            ffbt_pkg::S_F_PF: begin
                n_state = ffbt_pkg::S_F_NR;
                if (PW'(f_q) + HU <= r_b) begin
                    // merge with the free block below
                    p = r_b - HU - PW'(f_q);
                    h_raddr = AW'(p);
                    n_s = PW'(f_q) + HU + r_s;
                    n_b = p;
                    n_state = ffbt_pkg::S_F_PH;
                end
            end
            ffbt_pkg::S_F_PH: begin
                n_keep = q_pf;
                n_state = ffbt_pkg::S_F_NR;
            end
            ffbt_pkg::S_F_NR: begin
                h_raddr = AW'(r_b + HU + r_s);
                n_state = (r_b + HU + r_s < bp_w) ? ffbt_pkg::S_F_NX
                                                  : ffbt_pkg::S_F_WR;
            end
            ffbt_pkg::S_F_NX: begin
                if (q_free) begin
                    n_s = r_s + HU + q_size;
                end
                n_state = ffbt_pkg::S_F_WR;
            end
            ffbt_pkg::S_F_WR: begin
                h_we = 1'b1;
                h_waddr = AW'(r_b);
                h_wdata = {SW'(r_s), r_keep, 1'b1};
                f_we = 1'b1;
                f_waddr = AW'(r_b + HU + r_s - 1'b1);
                f_wdata = SW'(r_s);
                n_e = r_b + HU + r_s;
                n_flag = 1'b1;
                n_state = ffbt_pkg::S_T_RD;
            end
            ffbt_pkg::S_T_RD: begin
                h_raddr = AW'(r_e);
                n_state = (r_e < bp_w) ? ffbt_pkg::S_T_WR : ffbt_pkg::S_DONE;
            end
            ffbt_pkg::S_T_WR: begin
                h_we = 1'b1;
                h_waddr = AW'(r_e);
                h_wdata = {h_q[HW-1:2], r_flag, h_q[0]};
                n_state = ffbt_pkg::S_DONE;
            end
            ffbt_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = ffbt_pkg::S_IDLE;
                end
            end
            default: n_state = ffbt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffbt_pkg::S_IDLE;
            r_bp    <= '0;
            r_lim   <= ARENA;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bp    <= n_bp;
            if (i_cfg_we) begin
                r_lim <= i_cfg_data;
            end
            if (r_state == ffbt_pkg::S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_g <= n_g; r_tgt <= n_tgt; r_s <= n_s; r_b <= n_b;
        r_keep <= n_keep; r_lastf <= n_lastf; r_hlo <= n_hlo;
        r_e <= n_e; r_flag <= n_flag; r_addr <= n_addr; r_st <= n_st;
        if (r_state == ffbt_pkg::S_DONE && out_free) begin
            r_oaddr <= r_addr;
            r_ost   <= r_st;
        end
    end
endmodule

>>> hdl/ffbt_checker.sv
// Port-level checks for the first-fit boundary tag allocator, bound to the top.
// Depends on ffbt_pkg and first_fit_boundary_tag_allocator.
module ffbt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [11:0] o_payload_address,
    input logic [1:0]  o_status
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_payload_address)
                                && $stable(o_status))
        else $error("stalled result changed");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ffbt_pkg::ST_EXHAUSTED)
        else $error("undefined status code");

    a_fail_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ffbt_pkg::ST_DONE |-> o_payload_address == 12'd0)
        else $error("failed request returned an address");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");
endmodule

bind first_fit_boundary_tag_allocator ffbt_checker u_ffbt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_payload_address(o_payload_address), .o_status(o_status)
);

>>> tb/first_fit_boundary_tag_allocator_tb.sv
// Self-checking testbench for first_fit_boundary_tag_allocator: directed table, then random
// allocate/free traffic checked against an in-bench heap predictor.
// Depends on ffbt_pkg and the allocator RTL.
module first_fit_boundary_tag_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODE_ALLOC = 0;
    localparam int MODE_FREE  = 1;
    localparam int WDOG_LIMIT = 40000;
    localparam int RAND_ITEMS = 1030;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_mode;
    logic [15:0] i_request_bytes;
    logic [11:0] i_free_address;
    logic        o_valid;
    logic        i_ready;
    logic [11:0] o_payload_address;
    logic [1:0]  o_status;
    logic        i_cfg_we;
    logic [12:0] i_cfg_data;

    first_fit_boundary_tag_allocator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_request_bytes(i_request_bytes),
        .i_free_address(i_free_address),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_payload_address(o_payload_address), .o_status(o_status),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    typedef struct packed {
        logic [11:0] addr;
        logic [1:0]  status;
    } t_alloc_result;

    // ---------------- heap predictor ----------------
    // Header entry: bit0 free, bit1 previous free, size above.
    int unsigned heap_hdr [ffbt_pkg::ARENA_UNITS];
    int unsigned heap_ftr [ffbt_pkg::ARENA_UNITS];
    int unsigned heap_brk;
    int unsigned heap_limit;
    t_alloc_result pending_results[$];
    int unsigned live_blocks[$];   // payload addresses we believe are allocated

    function automatic int unsigned hdr_rd(int unsigned a);
        return (a < ffbt_pkg::ARENA_UNITS) ? heap_hdr[a] : 0;
    endfunction

    function automatic void mark_prev(int unsigned a, bit f);
        if (a < heap_brk && a < ffbt_pkg::ARENA_UNITS)
            heap_hdr[a] = (heap_hdr[a] & ~32'd2) | (f ? 32'd2 : 32'd0);
    endfunction

    function automatic void ftr_wr(int unsigned blk, int unsigned sz);
        int unsigned a;
        a = blk + ffbt_pkg::HEADER_UNITS + sz - 1;
        if (a < ffbt_pkg::ARENA_UNITS) heap_ftr[a] = sz;
    endfunction

    function automatic t_alloc_result heap_alloc(int unsigned req);
        t_alloc_result r;
        int unsigned g, a, steps, h, s, n, ns, lim;
        bit last_free;
        r = '0;
        a = 0; steps = 0; last_free = 0;
        if (req == 0) begin
            r.status = ffbt_pkg::ST_ZERO;
            return r;
        end
        g = (req + 7) / 8;
        while (a < heap_brk && steps <= ffbt_pkg::ARENA_UNITS) begin
            h = hdr_rd(a);
            s = h >> 2;
            if (h[0] && s >= g) begin
                if (s >= g + ffbt_pkg::HEADER_UNITS + 1 + ffbt_pkg::FOOTER_UNITS) begin
                    n  = a + ffbt_pkg::HEADER_UNITS + g;
                    ns = s - g - ffbt_pkg::HEADER_UNITS;
                    if (n < ffbt_pkg::ARENA_UNITS) heap_hdr[n] = (ns << 2) | 1;
                    ftr_wr(n, ns);
                    mark_prev(n + ffbt_pkg::HEADER_UNITS + ns, 1'b1);
                    s = g;
                end
                if (a < ffbt_pkg::ARENA_UNITS) heap_hdr[a] = (s << 2) | (h & 2);
                mark_prev(a + ffbt_pkg::HEADER_UNITS + s, 1'b0);
                r.addr = 12'(a + ffbt_pkg::HEADER_UNITS);
                return r;
            end
            last_free = h[0];
            if (s == 0) break;
            a += ffbt_pkg::HEADER_UNITS + s;
            steps++;
        end
        lim = (heap_limit < ffbt_pkg::ARENA_UNITS) ? heap_limit : ffbt_pkg::ARENA_UNITS;
        if (heap_brk > lim || lim - heap_brk < ffbt_pkg::HEADER_UNITS + g) begin
            r.status = ffbt_pkg::ST_EXHAUSTED;
            return r;
        end
        a = heap_brk;
        if (a < ffbt_pkg::ARENA_UNITS) heap_hdr[a] = (g << 2) | (last_free ? 2 : 0);
        heap_brk += ffbt_pkg::HEADER_UNITS + g;
        r.addr = 12'(a + ffbt_pkg::HEADER_UNITS);
        return r;
    endfunction

    function automatic void heap_free(int unsigned fa);
        int unsigned a, steps, tgt, h, s, b, keep, n, ps, p, nh;
        a = 0; steps = 0;
        if (fa < ffbt_pkg::HEADER_UNITS || heap_brk == 0) return;
        tgt = fa - ffbt_pkg::HEADER_UNITS;
        while (a < heap_brk && steps <= ffbt_pkg::ARENA_UNITS) begin
            if (a == tgt || (hdr_rd(a) >> 2) == 0) break;
            a += ffbt_pkg::HEADER_UNITS + (hdr_rd(a) >> 2);
            steps++;
        end
        if (a != tgt || a >= heap_brk) return;
        h = hdr_rd(a);
        if (h[0]) return;
        s = h >> 2; b = a; keep = h & 2;
        if (b != 0 && h[1]) begin
            ps = heap_ftr[b - 1];
            if (ps + ffbt_pkg::HEADER_UNITS <= b) begin
                p = b - ffbt_pkg::HEADER_UNITS - ps;
                keep = hdr_rd(p) & 2;
                s = ps + ffbt_pkg::HEADER_UNITS + s;
                b = p;
            end
        end
        n = b + ffbt_pkg::HEADER_UNITS + s;
        if (n < heap_brk) begin
            nh = hdr_rd(n);
            if (nh[0]) s += ffbt_pkg::HEADER_UNITS + (nh >> 2);
        end
        heap_hdr[b] = (s << 2) | keep | 1;
        ftr_wr(b, s);
        mark_prev(b + ffbt_pkg::HEADER_UNITS + s, 1'b1);
    endfunction

    // Side-effect-free look at an allocate result, for the directed table.
    function automatic t_alloc_result heap_alloc_peek(int unsigned req);
        int unsigned save_hdr [ffbt_pkg::ARENA_UNITS];
        int unsigned save_ftr [ffbt_pkg::ARENA_UNITS];
        int unsigned save_brk;
        t_alloc_result r;
        save_hdr = heap_hdr;
        save_ftr = heap_ftr;
        save_brk = heap_brk;
        r = heap_alloc(req);
        heap_hdr = save_hdr;
        heap_ftr = save_ftr;
        heap_brk = save_brk;
        return r;
    endfunction

    // ---------------- checking ----------------
    int  mismatches;
    int  idle_cycles;
    bit  rx_free_run;      // no random stalls on the receive side
    bit  rx_hold;          // long hold-off request
    int  done_results;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_alloc_result want;
            done_results <= done_results + 1;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: addr=%0d status=%0d",
                             o_payload_address, o_status);
            end else begin
                want = pending_results.pop_front();
                if (want.addr !== o_payload_address || want.status !== o_status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected addr=%0d status=%0d,",
                                  " got addr=%0d status=%0d"},
                                 want.addr, want.status, o_payload_address, o_status);
                end
            end
        end
    end

    // Receiver: random stalls, optional long hold-off.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) i_ready <= 1'b0;
            else if (rx_free_run) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(99) >= 37);
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    bit tx_free_run;

    // One request transfer; prediction made when it is accepted. Valid stays
    // up after the transfer until the next request or an idle cycle drops it.
    task automatic send_req(input bit mode, input int unsigned bytes,
                            input int unsigned fa);
        t_alloc_result r;
        if (!tx_free_run) begin
            while ($urandom_range(99) < 37) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_request_bytes <= 16'(bytes);
        i_free_address  <= 12'(fa);
        do @(posedge i_clk); while (!o_ready);
        r = '0;
        if (mode == MODE_FREE) begin
            heap_free(fa);
            for (int k = 0; k < live_blocks.size(); k++)
                if (live_blocks[k] == fa) begin
                    live_blocks.delete(k);
                    break;
                end
        end else begin
            r = heap_alloc(bytes);
            if (r.status == ffbt_pkg::ST_DONE) live_blocks.push_back(r.addr);
        end
        pending_results.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_limit(input int unsigned v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= 13'(v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        heap_limit = v;
    endtask

    // Directed table; exp_status/exp_addr used only when chk is set, the
    // predictor is cross-checked against them.
    typedef struct {
        bit          mode;
        int unsigned bytes;
        int unsigned fa;
        bit          chk;
        int unsigned exp_addr;
        int unsigned exp_status;
    } t_stim_row;

    t_stim_row dir_tab[] = '{
        '{MODE_FREE,  0,     0,    1, 0,  ffbt_pkg::ST_DONE},      // null free, empty arena
        '{MODE_FREE,  0,     5,    1, 0,  ffbt_pkg::ST_DONE},      // free before any block
        '{MODE_ALLOC, 0,     0,    1, 0,  ffbt_pkg::ST_ZERO},      // zero size
        '{MODE_ALLOC, 1,     0,    1, 2,  ffbt_pkg::ST_DONE},      // first block at 0
        '{MODE_ALLOC, 8,     0,    1, 5,  ffbt_pkg::ST_DONE},
        '{MODE_ALLOC, 32768, 0,    1, 0,  ffbt_pkg::ST_EXHAUSTED}, // too large
        '{MODE_ALLOC, 65535, 0,    1, 0,  ffbt_pkg::ST_EXHAUSTED},
        '{MODE_ALLOC, 100,   0,    0, 0,  0},
        '{MODE_ALLOC, 40,    0,    0, 0,  0},
        '{MODE_FREE,  0,     5,    0, 0,  0},            // free middle
        '{MODE_FREE,  0,     5,    0, 0,  0},            // double free
        '{MODE_FREE,  0,     6,    0, 0,  0},            // not a payload
        '{MODE_FREE,  0,     2,    0, 0,  0},            // merge with next free
        '{MODE_ALLOC, 7,     0,    0, 0,  0},            // reuse without split
        '{MODE_FREE,  0,     4095, 0, 0,  0},
        '{MODE_FREE,  0,     1,    0, 0,  0},
        '{MODE_ALLOC, 16,    0,    0, 0,  0},
        '{MODE_ALLOC, 32000, 0,    0, 0,  0},            // large block near limit
        '{MODE_ALLOC, 16,    0,    0, 0,  0}
    };

    initial begin
        int unsigned bytes, fa, pick, lim_choice;
        mismatches   = 0;
        done_results = 0;
        idle_cycles  = 0;
        rx_free_run  = 1'b0;
        rx_hold      = 1'b0;
        tx_free_run  = 1'b0;
        heap_brk     = 0;
        heap_limit   = 4096;
        foreach (heap_hdr[k]) begin
            heap_hdr[k] = 0;
            heap_ftr[k] = 0;
        end
        i_rst_n = 1'b0; i_valid = 1'b0; i_mode = 1'b0;
        i_request_bytes = '0; i_free_address = '0;
        i_cfg_we = 1'b0; i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part.
        foreach (dir_tab[k]) begin
            if (dir_tab[k].chk) begin
                t_alloc_result peek;
                peek = (dir_tab[k].mode == MODE_ALLOC) ?
                       heap_alloc_peek(dir_tab[k].bytes) : '0;
                if (peek.addr != dir_tab[k].exp_addr
                    || peek.status != dir_tab[k].exp_status) begin
                    mismatches++;
                    $display("table row %0d disagrees with predictor", k);
                end
            end
            send_req(dir_tab[k].mode, dir_tab[k].bytes, dir_tab[k].fa);
        end

        // Limit extremes: zero, then just above break, then full.
        write_limit(0);
        send_req(MODE_ALLOC, 4, 0);       // fits a freed hole or exhausts
        send_req(MODE_ALLOC, 32768, 0);
        write_limit(heap_brk + 3);
        send_req(MODE_ALLOC, 8, 0);
        send_req(MODE_ALLOC, 8, 0);
        write_limit(8191);
        send_req(MODE_ALLOC, 8, 0);

        // Reset heap content by freeing all live blocks.
        while (live_blocks.size() != 0) send_req(MODE_FREE, 0, live_blocks[0]);

        // Random part in phases with different limits.
        for (int ph = 0; ph < 6; ph++) begin
            lim_choice = $urandom_range(3);
            case (lim_choice)
                0: write_limit(4096);
                1: write_limit($urandom_range(8191, 4097));
                2: write_limit(heap_brk + $urandom_range(400));
                default: write_limit($urandom_range(heap_brk));
            endcase
            tx_free_run = (ph == 2);
            rx_free_run = (ph == 2);
            if (ph == 3) begin
                // long receiver hold-off while requests keep coming
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (300) @(negedge i_clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < RAND_ITEMS / 6; k++) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    case ($urandom_range(9))
                        0:       bytes = $urandom_range(65535);
                        1:       bytes = 0;
                        2:       bytes = $urandom_range(4096, 1024);
                        default: bytes = $urandom_range(200, 1);
                    endcase
                    send_req(MODE_ALLOC, bytes, $urandom_range(4095));
                end else if (pick < 90 && live_blocks.size() != 0) begin
                    fa = live_blocks[$urandom_range(live_blocks.size() - 1)];
                    send_req(MODE_FREE, $urandom_range(65535), fa);
                end else begin
                    // random address: invalid, null or double free
                    fa = ($urandom_range(3) == 0) ? 0 : $urandom_range(4095);
                    send_req(MODE_FREE, $urandom_range(65535), fa);
                end
                if (k == 40 && ph == 4) drain();   // sender pause until all results arrive
            end
            if (live_blocks.size() > 60 || heap_brk > 3800)
                while (live_blocks.size() != 0) send_req(MODE_FREE, 0, live_blocks[0]);
        end

        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
